// ----- rtl/ctd_pkg.sv -----
// Shared constants, widths and controller command types for the contingent TPDF dither block.
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

	// Input format and scaling into Q.24
	localparam int FRAC_BITS = 16;
	localparam int SCALE_SH  = (24 - FRAC_BITS < 0) ? 0 :
		((24 - FRAC_BITS > 16) ? 16 : 24 - FRAC_BITS);
	localparam int IN_W  = 40;
	localparam int X_W   = IN_W + SCALE_SH + 2;
	localparam int SUM_W = X_W + 1;
	localparam int Y_W   = SUM_W - 24;

	// Datapath widths
	localparam int RS_W  = 18;
	localparam int RND_W = 21;
	localparam int D_W   = 23;
	localparam int C_W   = 18;
	localparam int OMC_W = 19;
	localparam int MA_W  = 23;
	localparam int MB_W  = 20;
	localparam int P_W   = MA_W + MB_W;

	// Q.18 constants
	localparam logic [18:0] K_PHI            = 19'd424158;
	localparam logic [18:0] K_OMEGA          = 19'd148673;
	localparam logic [18:0] K_EXPC           = 19'd17298;
	localparam logic [18:0] K_ONE_MINUS_EXPC = 19'd244846;
	localparam logic [18:0] K_HALF           = 19'd131072;

	localparam logic signed [X_W-1:0] OFFSET_X = X_W'(100401 * 64);
	localparam logic signed [Y_W-1:0] Y_MAX    = Y_W'(8388607);
	localparam logic signed [Y_W-1:0] Y_MIN    = Y_W'(-8388608);
	localparam logic signed [23:0]    OUT_MAX  = 24'sh7FFFFF;
	localparam logic signed [23:0]    OUT_MIN  = 24'sh800000;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL_RS,
		OP_MUL_ERR,
		OP_MUL_M,
		OP_MUL_SHAPE,
		OP_DITHER,
		OP_MUL_APPLY,
		OP_FINISH
	} ctd_op_t;

	typedef struct packed {
		logic    load;
		ctd_op_t op;
	} ctd_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ctd_datapath.sv -----
// Datapath of the dither block: shared multiplier, working registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module ctd_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ctd_pkg::ctd_cmd_t            cmd,
	input  wire logic signed [ctd_pkg::IN_W-1:0] input_sample,
	input  wire logic [15:0]                  rand_a,
	input  wire logic [15:0]                  rand_b,
	output logic signed [23:0]                dithered_sample,
	output logic                              clipped
);
	import ctd_pkg::*;

	logic signed [X_W-1:0]   x_q;
	logic signed [RS_W-1:0]  rs_q;
	logic [15:0]             e_q;
	logic [15:0]             err_q;
	logic [16:0]             m_q;
	logic signed [RND_W-1:0] rnd_q;
	logic [C_W-1:0]          c_q;
	logic signed [D_W-1:0]   d_q;
	logic signed [P_W-1:0]   p_q;
	logic                    phase_q;
	logic signed [23:0]      dithered_sample_q;
	logic                    clipped_q;

	logic signed [X_W-1:0]   x_load;
	logic signed [X_W-1:0]   x_off;
	logic [23:0]             mag_lo;
	logic [16:0]             t_val;
	logic [16:0]             m_next;
	logic [C_W-1:0]          p_q16;
	logic [OMC_W-1:0]        omc;
	logic signed [D_W-1:0]   c_ext;
	logic signed [D_W-1:0]   d_next;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [P_W-1:0]   product;
	logic signed [SUM_W-1:0] sum;
	logic signed [Y_W-1:0]   y_val;
	logic                    over;
	logic                    under;

	always_comb begin
		x_load = X_W'(input_sample) <<< SCALE_SH;
		if (input_sample == '0) begin
			x_off = '0;
		end else if (input_sample[IN_W-1]) begin
			x_off = -OFFSET_X;
		end else begin
			x_off = OFFSET_X;
		end

		// fraction of |x| only needs the low 24 bits of the negation
		mag_lo = x_q[X_W-1] ? (24'd0 - x_q[23:0]) : x_q[23:0];

		// triangle of the new error
		t_val  = {e_q, 1'b0};
		m_next = (t_val > 17'd65536) ? 17'(18'd131072 - {1'b0, t_val}) : t_val;

		p_q16 = p_q[16 +: C_W];
		omc   = K_ONE_MINUS_EXPC - {1'b0, p_q16};

		c_ext  = D_W'({1'b0, c_q});
		d_next = D_W'(p_q >>> 18) + (phase_q ? c_ext : -c_ext) + D_W'(K_HALF);

		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_RS: begin
				mul_a = MA_W'(rs_q);
				mul_b = MB_W'({1'b0, K_PHI});
			end
			OP_MUL_ERR: begin
				mul_a = MA_W'({1'b0, err_q});
				mul_b = MB_W'({1'b0, K_OMEGA});
			end
			OP_MUL_M: begin
				mul_a = MA_W'({1'b0, m_q});
				mul_b = MB_W'({1'b0, K_OMEGA});
			end
			OP_MUL_SHAPE: begin
				mul_a = MA_W'(rnd_q);
				mul_b = MB_W'({1'b0, omc});
			end
			OP_MUL_APPLY: begin
				mul_a = MA_W'(d_q);
				mul_b = MB_W'({1'b0, c_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		product = mul_a * mul_b;

		sum   = SUM_W'(x_q) + SUM_W'(p_q >>> 12);
		y_val = Y_W'(sum >>> 24);
		over  = (y_val > Y_MAX);
		under = (y_val < Y_MIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cmd.op == OP_MUL_ERR) begin
				err_q <= e_q;
			end
			if (cmd.op == OP_FINISH) begin
				phase_q <= ~phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= x_load + x_off;
			rs_q <= $signed({2'b00, rand_a} + {2'b00, rand_b}) - 18'sd65536;
		end
		case (cmd.op)
			OP_MUL_RS: begin
				p_q <= product;
				e_q <= mag_lo[23:8];
			end
			OP_MUL_ERR: begin
				rnd_q <= RND_W'(p_q >>> 16);
				p_q   <= product;
				m_q   <= m_next;
			end
			OP_MUL_M: begin
				rnd_q <= rnd_q - RND_W'(p_q >>> 16);
				p_q   <= product;
			end
			OP_MUL_SHAPE: begin
				c_q <= p_q16 + C_W'(K_EXPC);
				p_q <= product;
			end
			OP_DITHER: begin
				d_q <= d_next;
			end
			OP_MUL_APPLY: begin
				p_q <= product;
			end
			OP_FINISH: begin
				clipped_q <= over | under;
				if (over) begin
					dithered_sample_q <= OUT_MAX;
				end else if (under) begin
					dithered_sample_q <= OUT_MIN;
				end else begin
					dithered_sample_q <= y_val[23:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign dithered_sample = dithered_sample_q;
	assign clipped         = clipped_q;

endmodule

`default_nettype wire

// ----- rtl/ctd_ctrl.sv -----
// Controller of the dither block: step sequencer and output valid register.
`timescale 1ns / 1ps
`default_nettype none

module ctd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ctd_pkg::ctd_cmd_t   cmd
);
	import ctd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RS,
		ST_ERR,
		ST_M,
		ST_SHAPE,
		ST_DITHER,
		ST_APPLY,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   finish;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// write the result once the output register is free or being emptied
	assign finish    = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE:   cmd.op = OP_NONE;
			ST_RS:     cmd.op = OP_MUL_RS;
			ST_ERR:    cmd.op = OP_MUL_ERR;
			ST_M:      cmd.op = OP_MUL_M;
			ST_SHAPE:  cmd.op = OP_MUL_SHAPE;
			ST_DITHER: cmd.op = OP_DITHER;
			ST_APPLY:  cmd.op = OP_MUL_APPLY;
			ST_FINISH: cmd.op = finish ? OP_FINISH : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_RS;
				ST_RS:     state_q <= ST_ERR;
				ST_ERR:    state_q <= ST_M;
				ST_M:      state_q <= ST_SHAPE;
				ST_SHAPE:  state_q <= ST_DITHER;
				ST_DITHER: state_q <= ST_APPLY;
				ST_APPLY:  state_q <= ST_FINISH;
				ST_FINISH: if (finish) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/contingent_tpdf_dither_24bit_top.sv -----
// Top level of the contingent TPDF dither quantizer to 24 bits.
// Input channel (in_valid/in_ready) carries one item: a 40-bit signed sample
// with 16 fraction bits in 24-bit steps, and two 16-bit random fractions.
// Output channel (out_valid/out_ready) carries one item per input item: the
// floored, saturated 24-bit code and a clip flag.
// The block works on one item at a time. in_ready is high only while the
// sequencer is idle; after acceptance the item takes five passes through
// the single shared 23x20 multiplier, one step that forms the dither and one
// that adds, floors and saturates. A new item is taken only once the
// sequencer is back in idle.
// out_valid rises once the finishing step writes the result register.
// The result sits in an output register: the next item is accepted while
// it waits. If the receiver still stalls when the next result is ready,
// the sequencer holds in its last step until the register empties.
// Reset clears the carried error and the phase bit and leaves the block
// idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module contingent_tpdf_dither_24bit_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [ctd_pkg::IN_W-1:0]  input_sample,
	input  wire logic [15:0]                      rand_a,
	input  wire logic [15:0]                      rand_b,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [23:0]                    dithered_sample,
	output logic                                  clipped
);
	import ctd_pkg::*;

	ctd_cmd_t cmd;

	ctd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ctd_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.input_sample    (input_sample),
		.rand_a          (rand_a),
		.rand_b          (rand_b),
		.dithered_sample (dithered_sample),
		.clipped         (clipped)
	);

	// an accepted item keeps the input closed while it is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##1 !in_ready ##1 !in_ready)
		else $error("input reopened too early after an accepted item");

	// a new result only appears at the end of a busy sequence
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without an item in work");

	// clipping implies the code sits at a 24-bit limit
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |->
			(dithered_sample == 24'sh7FFFFF || dithered_sample == 24'sh800000))
		else $error("clip flag set on an unsaturated code");

endmodule

`default_nettype wire
